// ----- rtl/core/sclip_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sclip_pkg
// Shared types and constants for the sprite clip and texture coordinate core.
// ----------------------------------------------------------------------------
package sclip_pkg;

  // Extra remainder bit kept by the divider so that shifted divisors never wrap.
  localparam int unsigned DIV_GUARD = 1;

  // Clip flags for one axis: the low edge and the high edge were moved.
  typedef struct packed {
    logic need_lo;
    logic need_hi;
  } edge_flags_t;

endpackage
`default_nettype wire

// ----- rtl/core/sclip_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sclip_div
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// ----------------------------------------------------------------------------
module sclip_div #(
  parameter int unsigned PW = 28,
  parameter int unsigned DW = 12,
  parameter int unsigned QB = 16
) (
  input  wire logic          clk,
  input  wire logic [PW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic      [QB-1:0] quotient,
  output logic               overflow
);
  import sclip_pkg::*;

  localparam int unsigned RW = PW + DIV_GUARD;

  logic [RW-1:0] rem_r [QB+1];
  logic [DW-1:0] div_r [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          ovf_r [QB+1];

  // The quotient would not fit in QB bits (this includes a zero divisor).
  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(dividend);
    div_r[0] <= divisor;
    q_r[0]   <= '0;
    ovf_r[0] <= RW'(dividend) >= (RW'(divisor) << QB);
  end

  for (genvar s = 0; s < QB; s++) begin : g_stage
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = RW'(div_r[s]) << (QB - 1 - s);
    assign ge    = rem_r[s] >= trial;
    always_ff @(posedge clk) begin
      rem_r[s+1] <= ge ? (rem_r[s] - trial) : rem_r[s];
      div_r[s+1] <= div_r[s];
      q_r[s+1]   <= {q_r[s][QB-2:0], ge};
      ovf_r[s+1] <= ovf_r[s];
    end
  end

  assign quotient = q_r[QB];
  assign overflow = ovf_r[QB];

endmodule
`default_nettype wire

// ----- rtl/core/sprite_clip_uv_adjust_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_clip_uv_adjust_core
// Clips a screen sprite against a clip rectangle and scales its texture
// coordinates in proportion to the amount cut from each edge.
// ----------------------------------------------------------------------------
//
//   channel   handshake            transfers at
//   in_*      start / busy         rising edge with start high and busy low
//   out_*     out_strobe           rising edge ending the strobe cycle
//
// One transaction is accepted per cycle; busy is always low.
// The depth from accept to the strobe cycle does not depend on COORD_BITS;
// it is set by the divider, which resolves one quotient bit per stage.
// Reset clears the valid bits of every stage; data registers are not reset.
// The receiver cannot stall, so the pipeline advances on every clock.
//
// Stages: front clip and cull, then four multiplies (offset times extent),
// then four parallel dividers by the original width or height, then the
// saturate and subtract step into the output register.
// ----------------------------------------------------------------------------
module sprite_clip_uv_adjust_core #(
  parameter int unsigned COORD_BITS   = 12,
  parameter int unsigned UV_FRAC_BITS = 15
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_is_text,
  input  wire logic [COORD_BITS-1:0]     in_scr_left,
  input  wire logic [COORD_BITS-1:0]     in_scr_top,
  input  wire logic [COORD_BITS-1:0]     in_scr_right,
  input  wire logic [COORD_BITS-1:0]     in_scr_bottom,
  input  wire logic [COORD_BITS-1:0]     in_clip_left,
  input  wire logic [COORD_BITS-1:0]     in_clip_top,
  input  wire logic [COORD_BITS-1:0]     in_clip_right,
  input  wire logic [COORD_BITS-1:0]     in_clip_bottom,
  input  wire logic [2*COORD_BITS-1:0]   in_orig_size,
  input  wire logic [UV_FRAC_BITS:0]     in_tex_u_extent,
  input  wire logic [UV_FRAC_BITS:0]     in_tex_v_extent,
  output logic                           out_strobe,
  output logic                           out_visible,
  output logic [COORD_BITS-1:0]          out_x_start,
  output logic [COORD_BITS-1:0]          out_y_start,
  output logic [COORD_BITS-1:0]          out_x_end,
  output logic [COORD_BITS-1:0]          out_y_end,
  output logic [UV_FRAC_BITS:0]          out_u_left,
  output logic [UV_FRAC_BITS:0]          out_v_top,
  output logic [UV_FRAC_BITS:0]          out_u_right,
  output logic [UV_FRAC_BITS:0]          out_v_bottom
);
  import sclip_pkg::*;

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned UW = UV_FRAC_BITS + 1;
  localparam int unsigned PW = C + UW;
  localparam int unsigned QB = UW;

  localparam logic [UW-1:0]       UV_ONE    = {1'b1, {UV_FRAC_BITS{1'b0}}};
  localparam logic signed [C:0]   COORD_MIN = {2'b11, {(C-1){1'b0}}};

  // Data that rides alongside the dividers.
  typedef struct packed {
    logic          visible;
    logic [C-1:0]  xs;
    logic [C-1:0]  ys;
    logic [C-1:0]  xe;
    logic [C-1:0]  ye;
    edge_flags_t   fx;
    edge_flags_t   fy;
    logic [UW-1:0] eu;
    logic [UW-1:0] ev;
  } side_t;

  typedef struct packed {
    side_t        side;
    logic [C-1:0] off_l;
    logic [C-1:0] off_t;
    logic [C-1:0] off_r;
    logic [C-1:0] off_b;
    logic [C-1:0] ow;
    logic [C-1:0] oh;
  } front_t;

  typedef struct packed {
    side_t         side;
    logic [PW-1:0] p_l;
    logic [PW-1:0] p_t;
    logic [PW-1:0] p_r;
    logic [PW-1:0] p_b;
    logic [C-1:0]  ow;
    logic [C-1:0]  oh;
  } prod_t;

  // The receiver cannot hold results off, so nothing ever backs up.
  assign busy = 1'b0;

  // ---------------------------------------------------------------- front --
  logic signed [C:0] sl, st, sr, sb, cl, ct, cr, cb;
  logic signed [C:0] xe0, ye0, xe1, ye1, xs1, ys1, d_l, d_t, d_r, d_b;
  logic              cull, need_l, need_t, need_r, need_b;
  front_t            front_nxt, front_r;
  logic              v1_r;

  always_comb begin
    sl = {in_scr_left[C-1], in_scr_left};
    st = {in_scr_top[C-1], in_scr_top};
    sr = {in_scr_right[C-1], in_scr_right};
    sb = {in_scr_bottom[C-1], in_scr_bottom};
    cl = {in_clip_left[C-1], in_clip_left};
    ct = {in_clip_top[C-1], in_clip_top};
    cr = {in_clip_right[C-1], in_clip_right};
    cb = {in_clip_bottom[C-1], in_clip_bottom};

    // The clip starts past the sprite's exclusive edge, or ends before it.
    cull = (cl > sr) || (ct > sb) || (sl > cr) || (st > cb);

    xe0 = sr - (C+1)'(1);
    ye0 = sb - (C+1)'(1);
    need_l = sl < cl;
    need_t = st < ct;
    need_r = xe0 > cr;
    need_b = ye0 > cb;
    xs1 = need_l ? cl : sl;
    ys1 = need_t ? ct : st;
    xe1 = need_r ? cr : xe0;
    ye1 = need_b ? cb : ye0;
    // Only the inclusive corner of an empty sprite at the far edge can underflow.
    if (xe1 < COORD_MIN) begin
      xe1 = COORD_MIN;
    end
    if (ye1 < COORD_MIN) begin
      ye1 = COORD_MIN;
    end
    d_l = cl - sl;
    d_t = ct - st;
    d_r = xe0 - cr;
    d_b = ye0 - cb;

    front_nxt.side.visible = !cull;
    front_nxt.side.xs      = xs1[C-1:0];
    front_nxt.side.ys      = ys1[C-1:0];
    front_nxt.side.xe      = xe1[C-1:0];
    front_nxt.side.ye      = ye1[C-1:0];
    front_nxt.side.fx      = '{need_lo: need_l, need_hi: need_r};
    front_nxt.side.fy      = '{need_lo: need_t, need_hi: need_b};
    front_nxt.side.eu      = !in_is_text ? UV_ONE :
                             (in_tex_u_extent > UV_ONE ? UV_ONE : in_tex_u_extent);
    front_nxt.side.ev      = !in_is_text ? UV_ONE :
                             (in_tex_v_extent > UV_ONE ? UV_ONE : in_tex_v_extent);
    front_nxt.off_l        = d_l[C-1:0];
    front_nxt.off_t        = d_t[C-1:0];
    front_nxt.off_r        = d_r[C-1:0];
    front_nxt.off_b        = d_b[C-1:0];
    front_nxt.ow           = in_orig_size[C-1:0];
    front_nxt.oh           = in_orig_size[2*C-1:C];
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
  end

  // ------------------------------------------------------------- multiply --
  prod_t prod_r;
  logic  v2_r;

  always_ff @(posedge clk) begin
    prod_r.side <= front_r.side;
    prod_r.p_l  <= PW'(front_r.off_l) * PW'(front_r.side.eu);
    prod_r.p_t  <= PW'(front_r.off_t) * PW'(front_r.side.ev);
    prod_r.p_r  <= PW'(front_r.off_r) * PW'(front_r.side.eu);
    prod_r.p_b  <= PW'(front_r.off_b) * PW'(front_r.side.ev);
    prod_r.ow   <= front_r.ow;
    prod_r.oh   <= front_r.oh;
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  // --------------------------------------------------------------- divide --
  logic [QB-1:0] q_l, q_t, q_r, q_b;
  logic          o_l, o_t, o_r, o_b;

  sclip_div #(.PW(PW), .DW(C), .QB(QB)) u_div_l (
    .clk(clk), .dividend(prod_r.p_l), .divisor(prod_r.ow), .quotient(q_l), .overflow(o_l)
  );
  sclip_div #(.PW(PW), .DW(C), .QB(QB)) u_div_t (
    .clk(clk), .dividend(prod_r.p_t), .divisor(prod_r.oh), .quotient(q_t), .overflow(o_t)
  );
  sclip_div #(.PW(PW), .DW(C), .QB(QB)) u_div_r (
    .clk(clk), .dividend(prod_r.p_r), .divisor(prod_r.ow), .quotient(q_r), .overflow(o_r)
  );
  sclip_div #(.PW(PW), .DW(C), .QB(QB)) u_div_b (
    .clk(clk), .dividend(prod_r.p_b), .divisor(prod_r.oh), .quotient(q_b), .overflow(o_b)
  );

  // Side data and valid bits, delayed to match the divider depth.
  side_t side_r [QB+1];
  logic  vd_r   [QB+1];

  always_ff @(posedge clk) begin
    side_r[0] <= prod_r.side;
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else begin
      vd_r[0] <= v2_r;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_side
    always_ff @(posedge clk) begin
      side_r[s+1] <= side_r[s];
      if (!rst_n) begin
        vd_r[s+1] <= 1'b0;
      end else begin
        vd_r[s+1] <= vd_r[s];
      end
    end
  end

  // --------------------------------------------------------------- finish --
  side_t         sd;
  logic [UW-1:0] s_l, s_t, s_r, s_b;
  logic          vis_nxt;
  logic [C-1:0]  xs_nxt, ys_nxt, xe_nxt, ye_nxt;
  logic [UW-1:0] ul_nxt, vt_nxt, ur_nxt, vb_nxt;
  logic          strobe_r, vis_r;
  logic [C-1:0]  xs_r, ys_r, xe_r, ye_r;
  logic [UW-1:0] ul_r, vt_r, ur_r, vb_r;

  always_comb begin
    sd = side_r[QB];
    // Quotients saturate at one; a zero size shows up as overflow.
    s_l = (o_l || q_l > UV_ONE) ? UV_ONE : q_l;
    s_t = (o_t || q_t > UV_ONE) ? UV_ONE : q_t;
    s_r = (o_r || q_r > UV_ONE) ? UV_ONE : q_r;
    s_b = (o_b || q_b > UV_ONE) ? UV_ONE : q_b;

    vis_nxt = sd.visible;
    xs_nxt  = sd.xs;
    ys_nxt  = sd.ys;
    xe_nxt  = sd.xe;
    ye_nxt  = sd.ye;
    ul_nxt  = sd.fx.need_lo ? s_l : '0;
    vt_nxt  = sd.fy.need_lo ? s_t : '0;
    ur_nxt  = !sd.fx.need_hi ? sd.eu : (s_r >= sd.eu ? '0 : sd.eu - s_r);
    vb_nxt  = !sd.fy.need_hi ? sd.ev : (s_b >= sd.ev ? '0 : sd.ev - s_b);

    // A culled sprite reports all zeros.
    if (!sd.visible) begin
      xs_nxt = '0;
      ys_nxt = '0;
      xe_nxt = '0;
      ye_nxt = '0;
      ul_nxt = '0;
      vt_nxt = '0;
      ur_nxt = '0;
      vb_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    vis_r <= vis_nxt;
    xs_r  <= xs_nxt;
    ys_r  <= ys_nxt;
    xe_r  <= xe_nxt;
    ye_r  <= ye_nxt;
    ul_r  <= ul_nxt;
    vt_r  <= vt_nxt;
    ur_r  <= ur_nxt;
    vb_r  <= vb_nxt;
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vd_r[QB];
    end
  end

  assign out_strobe   = strobe_r;
  assign out_visible  = vis_r;
  assign out_x_start  = xs_r;
  assign out_y_start  = ys_r;
  assign out_x_end    = xe_r;
  assign out_y_end    = ye_r;
  assign out_u_left   = ul_r;
  assign out_v_top    = vt_r;
  assign out_u_right  = ur_r;
  assign out_v_bottom = vb_r;

  // ----------------------------------------------------------- assertions --
  a_cull_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_visible |-> out_u_right == '0 && out_v_bottom == '0 &&
                                   out_x_end == '0 && out_y_end == '0)
    else $error("culled transaction carries nonzero fields");

  a_uv_lo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_u_left <= UV_ONE && out_v_top <= UV_ONE)
    else $error("left/top texture coordinate above one");

  a_uv_hi_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_u_right <= UV_ONE && out_v_bottom <= UV_ONE)
    else $error("right/bottom texture coordinate above one");

  a_chain: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r[QB] |=> out_strobe)
    else $error("divider output valid lost before the output register");

endmodule
`default_nettype wire

// ----- verif/sprite_clip_uv_adjust_core_tb.sv -----
// ----------------------------------------------------------------------------
// sprite_clip_uv_adjust_core_tb
// Self-checking bench for the sprite clip core. Sprites are sent through the
// start/busy port with random gaps. A behavioral model in this file computes
// the clipped corners and the scaled texture coordinates of each sprite, and
// every strobed result is compared with the oldest pending prediction.
// ----------------------------------------------------------------------------
module sprite_clip_uv_adjust_core_tb;

  localparam int CB  = 12;
  localparam int UVB = 15;
  localparam int ONE = 1 << UVB;
  localparam int CMIN = -(1 << (CB - 1));
  // Drain wait: the full pipeline depth with a margin on top of it.
  localparam int DRAIN_CYCLES = UVB + 12;
  localparam int WATCHDOG_LIMIT = 2000;

  // One sprite as driven onto the input ports.
  typedef struct {
    bit            is_text;
    bit [CB-1:0]   sl, st, sr, sb, cl, ct, cr, cb;
    bit [2*CB-1:0] orig;
    bit [UVB:0]    eu, ev;
  } sprite_t;

  // One quad as seen on the result ports.
  typedef struct {
    bit          visible;
    bit [CB-1:0] xs, ys, xe, ye;
    bit [UVB:0]  ul, vt, ur, vb;
  } quad_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_is_text = 1'b0;
  logic [CB-1:0] in_scr_left = '0, in_scr_top = '0, in_scr_right = '0, in_scr_bottom = '0;
  logic [CB-1:0] in_clip_left = '0, in_clip_top = '0, in_clip_right = '0;
  logic [CB-1:0] in_clip_bottom = '0;
  logic [2*CB-1:0] in_orig_size = '0;
  logic [UVB:0] in_tex_u_extent = '0, in_tex_v_extent = '0;
  logic out_strobe, out_visible;
  logic [CB-1:0] out_x_start, out_y_start, out_x_end, out_y_end;
  logic [UVB:0] out_u_left, out_v_top, out_u_right, out_v_bottom;

  quad_t pending_quads[$];
  int unsigned mismatch_count = 0;
  int unsigned sprites_sent = 0;
  int unsigned quads_checked = 0;
  int unsigned culled_seen = 0;
  int unsigned idle_cycles = 0;

  always #5 clk = ~clk;

  sprite_clip_uv_adjust_core #(.COORD_BITS(CB), .UV_FRAC_BITS(UVB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_is_text(in_is_text),
    .in_scr_left(in_scr_left), .in_scr_top(in_scr_top),
    .in_scr_right(in_scr_right), .in_scr_bottom(in_scr_bottom),
    .in_clip_left(in_clip_left), .in_clip_top(in_clip_top),
    .in_clip_right(in_clip_right), .in_clip_bottom(in_clip_bottom),
    .in_orig_size(in_orig_size),
    .in_tex_u_extent(in_tex_u_extent), .in_tex_v_extent(in_tex_v_extent),
    .out_strobe(out_strobe), .out_visible(out_visible),
    .out_x_start(out_x_start), .out_y_start(out_y_start),
    .out_x_end(out_x_end), .out_y_end(out_y_end),
    .out_u_left(out_u_left), .out_v_top(out_v_top),
    .out_u_right(out_u_right), .out_v_bottom(out_v_bottom)
  );

  // Offset times extent over the original size, truncated and capped at one.
  // A zero size means the edge was cut completely.
  function automatic longint uv_cut(longint off, longint ext, longint size);
    longint q;
    if (size == 0) begin
      return longint'(ONE);
    end
    q = (off * ext) / size;
    return (q > ONE) ? longint'(ONE) : q;
  endfunction

  // Work out the quad for one sprite. Coordinates are widened to int so the
  // edge differences cannot wrap.
  function automatic quad_t clip_sprite(sprite_t s);
    quad_t q;
    int sl, st, sr, sb, cl, ct, cr, cb, xs, ys, xe, ye;
    longint ow, oh, eu, ev, ul, vt, ur, vb;
    q = '{default: '0};
    sl = int'($signed(s.sl)); st = int'($signed(s.st));
    sr = int'($signed(s.sr)); sb = int'($signed(s.sb));
    cl = int'($signed(s.cl)); ct = int'($signed(s.ct));
    cr = int'($signed(s.cr)); cb = int'($signed(s.cb));
    ow = longint'(s.orig[CB-1:0]);
    oh = longint'(s.orig[2*CB-1:CB]);
    // The clip lies wholly past the sprite on some side: nothing is drawn.
    if (cl - sl > sr - sl || ct - st > sb - st || sl > cr || st > cb) begin
      return q;
    end
    eu = longint'(ONE); ev = longint'(ONE);
    if (s.is_text) begin
      eu = (s.eu > ONE) ? longint'(ONE) : longint'(s.eu);
      ev = (s.ev > ONE) ? longint'(ONE) : longint'(s.ev);
    end
    ul = 0; vt = 0; ur = eu; vb = ev;
    xs = sl; ys = st; xe = sr - 1; ye = sb - 1;
    if (xs < cl) begin
      ul = uv_cut(longint'(cl - xs), eu, ow);
      xs = cl;
    end
    if (ys < ct) begin
      vt = uv_cut(longint'(ct - ys), ev, oh);
      ys = ct;
    end
    if (xe > cr) begin
      ur = uv_cut(longint'(xe - cr), eu, ow);
      ur = (ur >= eu) ? longint'(0) : eu - ur;
      xe = cr;
    end
    if (ye > cb) begin
      vb = uv_cut(longint'(ye - cb), ev, oh);
      vb = (vb >= ev) ? longint'(0) : ev - vb;
      ye = cb;
    end
    // An exclusive edge at the most negative value would wrap; it is pinned.
    if (xe < CMIN) xe = CMIN;
    if (ye < CMIN) ye = CMIN;
    q.visible = 1'b1;
    q.xs = xs[CB-1:0]; q.ys = ys[CB-1:0]; q.xe = xe[CB-1:0]; q.ye = ye[CB-1:0];
    q.ul = ul[UVB:0]; q.vt = vt[UVB:0]; q.ur = ur[UVB:0]; q.vb = vb[UVB:0];
    return q;
  endfunction

  // Sends one sprite after a random gap and records its predicted quad when
  // the transaction is accepted. Start stays high between back-to-back sprites.
  task automatic send_sprite(sprite_t s);
    int gap;
    gap = int'($urandom_range(0, 14));
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_is_text <= s.is_text;
    in_scr_left <= s.sl; in_scr_top <= s.st; in_scr_right <= s.sr; in_scr_bottom <= s.sb;
    in_clip_left <= s.cl; in_clip_top <= s.ct; in_clip_right <= s.cr;
    in_clip_bottom <= s.cb;
    in_orig_size <= s.orig;
    in_tex_u_extent <= s.eu; in_tex_v_extent <= s.ev;
    do @(posedge clk); while (busy !== 1'b0);
    pending_quads.insert(pending_quads.size(), clip_sprite(s));
    sprites_sent++;
  endtask

  // Lowers start right at the accepting edge and waits until every predicted
  // quad has been checked.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_quads.size() != 0) @(posedge clk);
  endtask

  function automatic sprite_t rand_sprite();
    sprite_t s;
    s.is_text = 1'($urandom_range(0, 1));
    s.sl = 12'($urandom); s.st = 12'($urandom); s.sr = 12'($urandom); s.sb = 12'($urandom);
    s.cl = 12'($urandom); s.ct = 12'($urandom); s.cr = 12'($urandom); s.cb = 12'($urandom);
    s.orig = 24'($urandom);
    s.eu = 16'($urandom); s.ev = 16'($urandom);
    return s;
  endfunction

  // A sprite near a clip window of its own, so most are drawn and clipped on
  // some edges. Sizes and extents are mostly sensible, sometimes odd.
  function automatic sprite_t rand_overlapping_sprite();
    sprite_t s;
    int x0, y0, w, h, cw, ch, c0, c1;
    s = rand_sprite();
    x0 = int'($urandom_range(0, 3000)) - 1500;
    y0 = int'($urandom_range(0, 3000)) - 1500;
    w = int'($urandom_range(1, 300));
    h = int'($urandom_range(1, 300));
    c0 = x0 + int'($urandom_range(0, 2 * w)) - w / 2;
    cw = int'($urandom_range(0, 2 * w));
    c1 = y0 + int'($urandom_range(0, 2 * h)) - h / 2;
    ch = int'($urandom_range(0, 2 * h));
    s.sl = 12'(x0); s.sr = 12'(x0 + w); s.st = 12'(y0); s.sb = 12'(y0 + h);
    s.cl = 12'(c0); s.cr = 12'(c0 + cw); s.ct = 12'(c1); s.cb = 12'(c1 + ch);
    case ($urandom_range(0, 5))
      0: s.orig = 24'($urandom);
      1: s.orig = {12'($urandom_range(0, 3)), 12'($urandom_range(0, 3))};
      default: s.orig = {12'(h + int'($urandom_range(0, 8))),
                         12'(w + int'($urandom_range(0, 8)))};
    endcase
    case ($urandom_range(0, 3))
      0: begin s.eu = 16'($urandom); s.ev = 16'($urandom); end
      1: begin s.eu = 16'(ONE); s.ev = 16'(ONE); end
      default: begin
        s.eu = 16'($urandom_range(0, ONE));
        s.ev = 16'($urandom_range(0, ONE));
      end
    endcase
    return s;
  endfunction

  // Builds a sprite from signed corners.
  function automatic sprite_t make_sprite(bit text, int sl, int st, int sr, int sb,
                                          int cl, int ct, int cr, int cb,
                                          int ow, int oh, int eu, int ev);
    sprite_t s;
    s.is_text = text;
    s.sl = 12'(sl); s.st = 12'(st); s.sr = 12'(sr); s.sb = 12'(sb);
    s.cl = 12'(cl); s.ct = 12'(ct); s.cr = 12'(cr); s.cb = 12'(cb);
    s.orig = {12'(oh), 12'(ow)};
    s.eu = 16'(eu); s.ev = 16'(ev);
    return s;
  endfunction

  // Directed corner cases: culling on each side, clipping on each edge,
  // zero sizes, oversized extents, extreme coordinates and inverted quads.
  task automatic test_directed();
    send_sprite(make_sprite(1'b0, 10, 10, 20, 20, 0, 0, 100, 100, 10, 10, 0, 0));
    send_sprite(make_sprite(1'b1, 0, 0, 64, 64, 16, 8, 47, 55, 64, 64, 16384, 32768));
    // Cull from each of the four sides.
    send_sprite(make_sprite(1'b0, 0, 0, 10, 10, 11, 0, 50, 50, 10, 10, 0, 0));
    send_sprite(make_sprite(1'b0, 0, 0, 10, 10, 0, 11, 50, 50, 10, 10, 0, 0));
    send_sprite(make_sprite(1'b0, 60, 0, 70, 10, 0, 0, 50, 50, 10, 10, 0, 0));
    send_sprite(make_sprite(1'b0, 0, 60, 10, 70, 0, 0, 50, 50, 10, 10, 0, 0));
    // Clip equal to the width: just kept.
    send_sprite(make_sprite(1'b1, 0, 0, 10, 10, 10, 10, 50, 50, 10, 10, 32768, 32768));
    // Zero original size on a clipped edge saturates.
    send_sprite(make_sprite(1'b1, -5, -5, 5, 5, 0, 0, 2, 2, 0, 0, 32768, 20000));
    // Extents above one are taken as one.
    send_sprite(make_sprite(1'b1, 0, 0, 100, 100, 10, 10, 80, 80, 100, 100, 65535, 40000));
    // Tiny sizes push the quotient past one, so the right coordinate clamps at zero.
    send_sprite(make_sprite(1'b1, 0, 0, 100, 100, 50, 50, 60, 60, 3, 1, 30000, 12345));
    // Coordinate extremes, including corner underflow on the exclusive edge.
    send_sprite(make_sprite(1'b0, -2048, -2048, -2048, -2048, -2048, -2048, 2047, 2047,
                            4095, 4095, 0, 0));
    send_sprite(make_sprite(1'b1, -2048, -2048, 2047, 2047, -2048, -2048, 2047, 2047,
                            4095, 4095, 65535, 0));
    send_sprite(make_sprite(1'b1, -2048, -2048, 2047, 2047, 2047, 2047, -2048, -2048,
                            4095, 4095, 32768, 32768));
    send_sprite(make_sprite(1'b0, 2047, 2047, -2048, -2048, -2048, -2048, 2047, 2047,
                            1, 1, 0, 0));
    // Inverted result: the clip leaves the right edge left of the start.
    send_sprite(make_sprite(1'b0, 0, 0, 20, 20, 15, 15, 5, 5, 20, 20, 0, 0));
    send_sprite(make_sprite(1'b1, 100, 100, 50, 50, 0, 0, 1000, 1000, 7, 9, 1, 32767));
    // All input bits at one, then all at zero.
    send_sprite(make_sprite(1'b1, -1, -1, -1, -1, -1, -1, -1, -1, 4095, 4095, 65535, 65535));
    send_sprite(make_sprite(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Mostly overlapping sprites with random clipping, plus raw noise.
  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) send_sprite(rand_sprite());
      else send_sprite(rand_overlapping_sprite());
    end
  endtask

  // A stretch of back-to-back sprites with no gaps at all.
  task automatic test_back_to_back(int count);
    sprite_t s;
    for (int i = 0; i < count; i++) begin
      s = rand_overlapping_sprite();
      start <= 1'b1;
      in_is_text <= s.is_text;
      in_scr_left <= s.sl; in_scr_top <= s.st; in_scr_right <= s.sr;
      in_scr_bottom <= s.sb;
      in_clip_left <= s.cl; in_clip_top <= s.ct; in_clip_right <= s.cr;
      in_clip_bottom <= s.cb;
      in_orig_size <= s.orig;
      in_tex_u_extent <= s.eu; in_tex_v_extent <= s.ev;
      do @(posedge clk); while (busy !== 1'b0);
      pending_quads.insert(pending_quads.size(), clip_sprite(s));
      sprites_sent++;
    end
  endtask

  // Result checker: each strobed transaction against the oldest prediction.
  always @(posedge clk) begin
    quad_t exp_q;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_quads.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual visible=%0b", $time,
                 out_visible);
        mismatch_count++;
      end else begin
        exp_q = pending_quads.pop_front();
        quads_checked++;
        if (!exp_q.visible) culled_seen++;
        if (out_visible !== exp_q.visible || out_x_start !== exp_q.xs ||
            out_y_start !== exp_q.ys || out_x_end !== exp_q.xe ||
            out_y_end !== exp_q.ye || out_u_left !== exp_q.ul ||
            out_v_top !== exp_q.vt || out_u_right !== exp_q.ur ||
            out_v_bottom !== exp_q.vb) begin
          $display("%0t: mismatch expected vis=%0b x=%0d..%0d y=%0d..%0d u=%0d..%0d v=%0d..%0d",
                   $time, exp_q.visible, $signed(exp_q.xs), $signed(exp_q.xe),
                   $signed(exp_q.ys), $signed(exp_q.ye), exp_q.ul, exp_q.ur,
                   exp_q.vt, exp_q.vb);
          $display("%0t:          actual   vis=%0b x=%0d..%0d y=%0d..%0d u=%0d..%0d v=%0d..%0d",
                   $time, out_visible, $signed(out_x_start), $signed(out_x_end),
                   $signed(out_y_start), $signed(out_y_end), out_u_left, out_u_right,
                   out_v_top, out_v_bottom);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction moves on either side.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending_quads.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    // The sender holds off here until the pipeline is empty.
    wait_for_drain();
    test_random(300);
    test_back_to_back(60);
    wait_for_drain();
    test_random(260);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d sprites, %0d quads checked, %0d of them culled",
             sprites_sent, quads_checked, culled_seen);
    if (mismatch_count == 0 && pending_quads.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/sclip_pkg.sv
rtl/core/sclip_div.sv
rtl/core/sprite_clip_uv_adjust_core.sv
verif/sprite_clip_uv_adjust_core_tb.sv
